[hw/rtl/unique_key_ordered_set_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the unique-key ordered set
// Concurrent checks on clk, idle while arst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_KEY_ORDERED_SET_TOP_DEFINES_SVH
`define UNIQUE_KEY_ORDERED_SET_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every edge.
`define UKOS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ukos check failed");
// Antecedent in one cycle implies consequent in the next.
`define UKOS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ukos sequence check failed");
`else
`define UKOS_ASSERT(label, prop)
`define UKOS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/ukos_pkg.sv]
// ----------------------------------------------------------------------------
// ukos_pkg
// Types, codes and fixed widths shared by the ordered-set modules.
// ----------------------------------------------------------------------------
package ukos_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int DEF_KEY_BITS = 32;

	localparam int ACTION_W    = 2;
	localparam int IN_KEY_W    = 32;
	localparam int POS_W       = 4;
	localparam int STATUS_W    = 3;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_DUP       = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;  // capture item, register match vector
		logic exec;  // apply update, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // result register empty or being drained
	} dp_stat_t;

endpackage

[hw/rtl/ukos_if.sv]
// ----------------------------------------------------------------------------
// ukos_in_if / ukos_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ukos_in_if import ukos_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic signed [IN_KEY_W-1:0] key;
	logic [POS_W-1:0]           position;

	modport source (output valid, action, key, position, input ready);
	modport sink   (input valid, action, key, position, output ready);
endinterface

interface ukos_out_if import ukos_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [IN_KEY_W-1:0] read_key;
	logic [COUNT_OUT_W-1:0]     entry_count;

	modport source (output valid, status, read_key, entry_count, input ready);
	modport sink   (input valid, status, read_key, entry_count, output ready);
endinterface

[hw/rtl/ukos_ctrl.sv]
// ----------------------------------------------------------------------------
// ukos_ctrl
// Two-state sequencer: capture an item, then apply it once the result slot frees.
// ----------------------------------------------------------------------------
module ukos_ctrl import ukos_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output cmd_t     cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

[hw/rtl/ukos_datapath.sv]
// ----------------------------------------------------------------------------
// ukos_datapath
// Row of key cells with per-cell match, shift-in/close-gap update, read mux
// and the result register.
// ----------------------------------------------------------------------------
module ukos_datapath import ukos_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int KEY_BITS = DEF_KEY_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output dp_stat_t                   stat,
	input  logic [ACTION_W-1:0]        in_action,
	input  logic signed [IN_KEY_W-1:0] in_key,
	input  logic [POS_W-1:0]           in_position,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        out_status,
	output logic signed [IN_KEY_W-1:0] out_read_key,
	output logic [COUNT_OUT_W-1:0]     out_entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// captured item and match vector
	action_t                    op_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [POS_W-1:0]           pos_q;
	logic [CAPACITY-1:0]        match_q;

	// key cells, newest at 0
	logic signed [KEY_BITS-1:0] store_q [CAPACITY];
	logic [CAPACITY-1:0]        valid_q;
	logic [CNT_W-1:0]           count_q;

	// result register
	logic                       out_valid_q;
	status_t                    out_status_q;
	logic signed [IN_KEY_W-1:0] out_key_q;
	logic [COUNT_OUT_W-1:0]     out_count_q;

	logic signed [KEY_BITS-1:0] key_in;
	logic                       found, full, in_range;
	logic [CAPACITY-1:0]        shift_from;
	logic [PW-1:0]              pos_w, count_w;
	logic signed [KEY_BITS-1:0] rd_key;
	logic signed [IN_KEY_W-1:0] rk;
	status_t                    st;
	logic                       do_ins, do_rem;
	logic [CNT_W-1:0]           count_nxt;

	assign key_in = KEY_BITS'(in_key);

	// capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= action_t'(in_action);
			key_q <= key_in;
			pos_q <= in_position;
			for (int i = 0; i < CAPACITY; i++) begin
				match_q[i] <= valid_q[i] && (store_q[i] == key_in);
			end
		end
	end

	// keys are unique, so at most one match bit is set
	always_comb begin
		shift_from = match_q;
		for (int s = 1; s < CAPACITY; s = s * 2) begin
			shift_from = shift_from | (shift_from << s);
		end
	end

	assign found   = |match_q;
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign pos_w   = PW'(pos_q);
	assign count_w = PW'(count_q);
	assign in_range = (pos_w < count_w);

	always_comb begin
		rd_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pos_w == PW'(i)) begin
				rd_key = store_q[i];
			end
		end
	end

	always_comb begin
		st        = ST_OK;
		rk        = '0;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		count_nxt = count_q;
		case (op_q)
			ACT_INSERT: begin
				if (found) begin
					st = ST_DUP;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					do_ins    = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				if (!found) begin
					st = ST_NOT_FOUND;
				end else begin
					do_rem    = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			ACT_READ: begin
				if (in_range) begin
					rk = IN_KEY_W'(rd_key);
				end else begin
					st = ST_RANGE;
				end
			end
			default: ;
		endcase
	end

	// key cells: shift back on insert, close the gap on remove
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (do_ins) begin
				store_q[0] <= key_q;
				for (int i = 1; i < CAPACITY; i++) begin
					store_q[i] <= store_q[i-1];
				end
			end else if (do_rem) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (shift_from[i]) begin
						store_q[i] <= store_q[i+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_nxt;
			if (do_ins) begin
				valid_q <= {valid_q[CAPACITY-2:0], 1'b1};
			end else if (do_rem) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (shift_from[i]) begin
						valid_q[i] <= valid_q[i+1];
					end
				end
				valid_q[CAPACITY-1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_status_q <= st;
			out_key_q    <= rk;
			out_count_q  <= COUNT_OUT_W'(count_nxt);
		end
	end

	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_read_key    = out_key_q;
	assign out_entry_count = out_count_q;

endmodule

[hw/rtl/unique_key_ordered_set_top.sv]
// Each item is captured, then applied; the apply step loads the result register.
// No new item is taken until the last one is applied; the match vector is registered
//   between the per-cell compare and the shift update: a capture step and an apply step.
// The apply cycle waits while a previous result sits untaken in the output register.
// Reset (arst_n low): count, valid bits, sequencer and output valid clear at once;
//   key cells are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// unique_key_ordered_set_top
// Ordered set of distinct signed keys, newest first: insert, remove, read.
// ----------------------------------------------------------------------------
`include "unique_key_ordered_set_top_defines.svh"

module unique_key_ordered_set_top import ukos_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,  // 2..31 key cells
	parameter int KEY_BITS = DEF_KEY_BITS   // stored key width, 8..64
) (
	input  logic         clk,
	input  logic         arst_n,
	ukos_in_if.sink      req,
	ukos_out_if.source   rsp
);

	cmd_t     cmd;
	dp_stat_t stat;
	logic     in_ready;

	// Sequencer: IDLE takes an item (ready high), EXEC applies it.
	ukos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	// Datapath: on capture each cell compares its key with the item's key
	// (truncated or sign-extended to KEY_BITS); on apply an insert shifts the
	// row back to take the new key at the front, and a remove has every cell at
	// or behind the hit pull from its neighbor to close the gap.
	ukos_datapath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_action       (req.action),
		.in_key          (req.key),
		.in_position     (req.position),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_read_key    (rsp.read_key),
		.out_entry_count (rsp.entry_count)
	);

	// One item in flight: in the cycle after an accept the input is closed.
	`UKOS_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
	// Apply only into a free result slot, so no result is overwritten.
	`UKOS_ASSERT(a_exec_slot_free, !cmd.exec || stat.out_free)
	// Capture and apply never coincide.
	`UKOS_ASSERT(a_cmd_exclusive, !(cmd.load && cmd.exec))
	// Every apply presents a result on the next cycle.
	`UKOS_ASSERT_NEXT(a_exec_gives_result, cmd.exec, rsp.valid)

endmodule

[tb/tb_unique_key_ordered_set_top.sv]
// ----------------------------------------------------------------------------
// tb_unique_key_ordered_set_top
// Self-checking bench for the ordered set of distinct keys. A shadow set,
// newest key first, predicts status, read key and count for every request.
// A short directed run covers empty, extreme and duplicate cases, then
// random phases fill and drain the set under bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_unique_key_ordered_set_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ukos_pkg::*;

	localparam int CAP          = DEF_CAPACITY;
	localparam int KEY_BITS     = DEF_KEY_BITS;
	localparam int RANDOM_OPS   = 800;
	localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving on either side
	localparam int DRAIN_CYCLES = 8;     // extra clocks after the last reply before the report
	localparam int POOL_SIZE    = 24;    // more keys than cells, so the set can fill

	localparam logic signed [IN_KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [IN_KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct {
		action_t                    action;
		logic signed [IN_KEY_W-1:0] key;
		logic [POS_W-1:0]           position;
	} set_op_t;

	typedef struct {
		status_t                    status;
		logic signed [IN_KEY_W-1:0] read_key;
		logic [COUNT_OUT_W-1:0]     entry_count;
	} set_reply_t;

	logic clk;
	logic arst_n;

	ukos_in_if  req ();
	ukos_out_if rsp ();

	unique_key_ordered_set_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Requests waiting to be driven, and replies the shadow set says are due.
	set_op_t    op_queue[$];
	set_reply_t reply_queue[$];

	// Shadow copy of the store, index 0 is the newest key.
	logic [KEY_BITS-1:0] shadow_keys[$];

	int unsigned ops_total;
	int unsigned ops_taken;
	int unsigned replies_seen;
	int unsigned errors;

	// Coverage tallies, bumped by the predictor.
	int unsigned n_ins_ok, n_dup, n_full, n_rem_ok, n_not_found, n_read_ok, n_range, n_none;
	int unsigned peak_count;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// Port key -> cell width: sign-extend, then keep the low KEY_BITS.
	function automatic logic [KEY_BITS-1:0] to_cell(logic signed [IN_KEY_W-1:0] k);
		logic signed [63:0] wide;
		wide = k;
		return wide[KEY_BITS-1:0];
	endfunction

	// Cell -> port: sign-extend from KEY_BITS, cut to the port width.
	function automatic logic signed [IN_KEY_W-1:0] to_port(logic [KEY_BITS-1:0] c);
		logic signed [KEY_BITS-1:0] s;
		logic signed [63:0]         wide;
		s    = c;
		wide = s;
		return wide[IN_KEY_W-1:0];
	endfunction

	function automatic int find_key(logic [KEY_BITS-1:0] c);
		foreach (shadow_keys[i])
			if (shadow_keys[i] == c)
				return i;
		return -1;
	endfunction

	// Applies one request to the shadow set and returns the reply it earns.
	function automatic set_reply_t predict_reply(set_op_t op);
		set_reply_t          r;
		logic [KEY_BITS-1:0] c;
		int                  hit;
		c          = to_cell(op.key);
		r.status   = ST_OK;
		r.read_key = '0;
		case (op.action)
			ACT_INSERT: begin
				// duplicate wins over full
				if (find_key(c) >= 0) begin
					r.status = ST_DUP;
					n_dup++;
				end else if (shadow_keys.size() >= CAP) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					shadow_keys.push_front(c);
					n_ins_ok++;
				end
			end
			ACT_REMOVE: begin
				hit = find_key(c);
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
					n_not_found++;
				end else begin
					shadow_keys.delete(hit);  // gap closes toward the front
					n_rem_ok++;
				end
			end
			ACT_READ: begin
				if (op.position < shadow_keys.size()) begin
					r.read_key = to_port(shadow_keys[op.position]);
					n_read_ok++;
				end else begin
					r.status = ST_RANGE;
					n_range++;
				end
			end
			default: n_none++;  // unused code: no change, plain ok
		endcase
		r.entry_count = COUNT_OUT_W'(shadow_keys.size());
		if (shadow_keys.size() > peak_count)
			peak_count = shadow_keys.size();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic add_op(action_t a, logic signed [IN_KEY_W-1:0] k, logic [POS_W-1:0] p);
		set_op_t op;
		op.action   = a;
		op.key      = k;
		op.position = p;
		op_queue.insert(op_queue.size(), op);
		ops_total++;
	endtask

	// Directed part: empty store, extremes of the key, duplicates, reads at
	// and past the end, removal at the front, middle and back, unused code.
	task automatic load_directed();
		add_op(ACT_READ, 32'sd0, 4'd0);             // read on empty store
		add_op(ACT_REMOVE, 32'sd5, 4'd0);           // remove from empty store
		add_op(ACT_NONE, $urandom(), POS_W'($urandom()));
		add_op(ACT_INSERT, KEY_MIN, 4'd0);
		add_op(ACT_INSERT, KEY_MAX, 4'd0);
		add_op(ACT_INSERT, 32'sd0, 4'd0);
		add_op(ACT_INSERT, -32'sd1, 4'd0);
		add_op(ACT_INSERT, KEY_MAX, 4'd0);          // duplicate
		add_op(ACT_READ, 32'sd0, 4'd0);
		add_op(ACT_READ, 32'sd0, 4'd3);             // last valid entry
		add_op(ACT_READ, 32'sd0, 4'd4);             // one past the end
		add_op(ACT_READ, 32'sd0, 4'd15);            // top position
		add_op(ACT_REMOVE, 32'sd0, 4'd0);           // middle entry
		add_op(ACT_REMOVE, 32'sd0, 4'd0);           // now missing
		add_op(ACT_READ, 32'sd0, 4'd2);
		add_op(ACT_REMOVE, KEY_MIN, 4'd0);          // oldest entry
		add_op(ACT_REMOVE, -32'sd1, 4'd0);          // newest entry
		add_op(ACT_INSERT, 32'sh5555_5555, 4'd0);
		add_op(ACT_INSERT, 32'shAAAA_AAAA, 4'd0);
		add_op(ACT_READ, 32'sd0, 4'd0);
		add_op(ACT_READ, 32'sd0, 4'd1);
		add_op(ACT_REMOVE, KEY_MAX, 4'd0);
		add_op(ACT_REMOVE, 32'sh5555_5555, 4'd0);
		add_op(ACT_REMOVE, 32'shAAAA_AAAA, 4'd0);   // back to empty
	endtask

	// Random part in phases of shifting insert weight, so the set fills to
	// capacity, drains to empty and churns in between. Keys come mostly from
	// a small pool so duplicates and hits on remove are common.
	task automatic load_random();
		logic signed [IN_KEY_W-1:0] pool[POOL_SIZE];
		int                         ins_pct[4] = '{90, 30, 65, 10};
		int                         counted;
		int                         phase;
		int                         phase_len;
		int                         roll;
		logic signed [IN_KEY_W-1:0] k;
		pool[0] = KEY_MIN;
		pool[1] = KEY_MAX;
		pool[2] = 32'sd0;
		pool[3] = -32'sd1;
		pool[4] = 32'sd1;
		for (int i = 5; i < POOL_SIZE; i++)
			pool[i] = $urandom();
		counted = 0;
		phase   = 0;
		while (counted < RANDOM_OPS) begin
			phase_len = $urandom_range(40, 120);
			for (int n = 0; n < phase_len && counted < RANDOM_OPS; n++) begin
				k    = ($urandom_range(0, 4) == 0) ? $urandom() : pool[$urandom_range(0, POOL_SIZE-1)];
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					add_op(ACT_NONE, k, POS_W'($urandom()));  // not counted
				end else begin
					counted++;
					if (roll < ins_pct[phase % 4])
						add_op(ACT_INSERT, k, POS_W'($urandom()));
					else if ($urandom_range(0, 1) == 0)
						add_op(ACT_REMOVE, k, POS_W'($urandom()));
					else
						add_op(ACT_READ, k, POS_W'($urandom()));
				end
			end
			phase++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of items with random gaps between bursts
	// ------------------------------------------------------------------
	set_op_t drv_op;
	int      burst_left;
	int      gap_left;

	always @(posedge clk) begin
		set_op_t nxt;
		if (!arst_n) begin
			req.valid  <= 1'b0;
			burst_left = 0;
			gap_left   = $urandom_range(0, 5);
		end else begin
			// item on the wires moves this edge: predict its reply now
			if (req.valid && req.ready) begin
				reply_queue.insert(reply_queue.size(), predict_reply(drv_op));
				ops_taken++;
			end
			if (!req.valid || req.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (op_queue.size() != 0) begin
					nxt            = op_queue.pop_front();
					drv_op         = nxt;
					req.valid      <= 1'b1;
					req.action     <= nxt.action;
					req.key        <= nxt.key;
					req.position   <= nxt.position;
					if (burst_left <= 1) begin
						// end of burst: a quarter of bursts run straight into the next
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: ready follows one of four stall modes, switched at random
	// ------------------------------------------------------------------
	int          rdy_mode;
	int          mode_left;
	int          stall_left;
	int unsigned rdy_tick;

	always @(posedge clk) begin
		logic nxt_ready;
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			rdy_mode   = 0;
			mode_left  = 0;
			stall_left = 0;
			rdy_tick   = 0;
		end else begin
			if (mode_left == 0) begin
				rdy_mode  = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 200);
			end
			mode_left--;
			rdy_tick++;
			case (rdy_mode)
				0: nxt_ready = 1'b1;                       // never stalls
				1: nxt_ready = 1'($urandom_range(0, 1));   // coin flip
				2: nxt_ready = (rdy_tick % 3) == 0;        // fixed one-in-three
				default: begin                             // long stalls, up to 20
					if (stall_left != 0) begin
						stall_left--;
						nxt_ready = 1'b0;
					end else begin
						stall_left = $urandom_range(1, 20);
						nxt_ready  = 1'b1;
					end
				end
			endcase
			rsp.ready <= nxt_ready;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every reply against the oldest predicted one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		set_reply_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			replies_seen++;
			if (reply_queue.size() == 0) begin
				$error("reply with no request outstanding: status %0d count %0d",
					rsp.status, rsp.entry_count);
				errors++;
			end else begin
				want = reply_queue.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.read_key !== want.read_key) begin
					$error("read_key: expected %0d, got %0d", want.read_key, rsp.read_key);
					errors++;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, rsp.entry_count);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no item moving on either channel
	// ------------------------------------------------------------------
	int unsigned idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d of %0d items taken, %0d replies outstanding",
					ops_taken, ops_total, reply_queue.size());
				$display("tb_unique_key_ordered_set_top failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, load stimulus, wait for the drain, report
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.action   = ACT_NONE;
		req.key      = '0;
		req.position = '0;
		rsp.ready    = 1'b0;
		load_directed();
		load_random();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_taken < ops_total)
			@(posedge clk);
		while (reply_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d replies: insert ok %0d, dup %0d, full %0d, remove ok %0d",
			ops_taken, replies_seen, n_ins_ok, n_dup, n_full, n_rem_ok);
		$display("not found %0d, read ok %0d, out of range %0d, unused code %0d, peak fill %0d",
			n_not_found, n_read_ok, n_range, n_none, peak_count);
		if (errors == 0 && reply_queue.size() == 0) begin
			$display("tb_unique_key_ordered_set_top passed");
		end else begin
			$display("tb_unique_key_ordered_set_top failed");
		end
		$finish;
	end

endmodule

[unique_key_ordered_set_top.f]
+incdir+hw/rtl
hw/rtl/ukos_pkg.sv
hw/rtl/ukos_if.sv
hw/rtl/ukos_ctrl.sv
hw/rtl/ukos_datapath.sv
hw/rtl/unique_key_ordered_set_top.sv
tb/tb_unique_key_ordered_set_top.sv
